/* src/sedd_pkg.sv */
// Package: shared constants, types and helpers for the serpentine dither block.
`timescale 1ns / 1ps
`default_nettype none

package sedd_pkg;

    // Stream payload widths
    localparam int PIX_W       = 8;
    localparam int Q_W         = 14;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int STEP_W     = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP   = 2'd2;

    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [STEP_W-1:0]   QUANT_STEP_RST   = 12'd16;

    // Output saturation limits (magnitudes)
    localparam int Q_POS_MAX = 8191;
    localparam int Q_NEG_MAG = 4096;

    // Stored error width
    localparam int ERR_W = 16;

    typedef enum logic [13:0] {
        ST_CLEAR = 14'h0001,
        ST_IDLE  = 14'h0002,
        ST_LOAD  = 14'h0004,
        ST_SUM   = 14'h0008,
        ST_ABS   = 14'h0010,
        ST_DIV   = 14'h0020,
        ST_MUL   = 14'h0040,
        ST_SAT   = 14'h0080,
        ST_ERR   = 14'h0100,
        ST_SHARE = 14'h0200,
        ST_WR_X  = 14'h0400,
        ST_WR_BH = 14'h0800,
        ST_WR_AH = 14'h1000,
        ST_OUT   = 14'h2000
    } sedd_state_t;

    // Clamp to the signed 16-bit error range
    function automatic logic signed [ERR_W-1:0] sat16(input logic signed [31:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/serpentine_error_diffusion_dither_top.sv */
// Top level: serpentine Floyd-Steinberg error-diffusion dither for one image plane.
`timescale 1ns / 1ps
`default_nettype none

// Serpentine error-diffusion dither. Feed 8-bit samples of one plane in
// serpentine order (even rows left to right, odd rows right to left) on the
// s_ stream; each sample plus its diffused error is rounded half away from
// zero to a multiple of quant_step, saturated to -4096..8191 (units of
// 2^-FRAC_BITS) and sent on the m_ stream, with m_tlast on the last pixel of
// the plane. Error goes 7/16 ahead in scan direction and 3/16, 5/16, 1/16 to
// the row below, mirrored on reverse rows; nothing goes below on the last row.
// One item at a time: s_tready is high only in the idle state, and each item
// passes through the load, sum, abs, divide, multiply, saturate, error, share,
// three write and output states before the next accept; the divide state
// repeats once per pass through the single two-bit-per-cycle restoring divider.
// Three error-store writes and three reads go through one single-write,
// dual-read line memory. A finished result sits in the output register while
// the next item is accepted; the block only stalls at the end of that item if
// the result is still untaken. After reset the block clears both line buffers,
// one entry a cycle, all 2 * MAX_WIDTH entries, before it first raises
// s_tready; register writes are taken at any time and the port should only be
// written while idle.

module serpentine_error_diffusion_dither_top
    import sedd_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // Configuration write channel
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    // Input stream
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] pixel_value

    // Result stream
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [TDATA_OUT_W-1:0] m_tdata,   // [13:0] quantized_value, [15:14] zero
    output      logic                   m_tlast    // frame_last
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int CW       = $clog2(MAX_WIDTH);        // column index
    localparam int WW       = $clog2(MAX_WIDTH + 1);    // column count incl. MAX_WIDTH
    localparam int DEPTH    = 2 * MAX_WIDTH;            // two line buffers
    localparam int AW       = $clog2(DEPTH);
    localparam int PIX_FX_W = PIX_W + FRAC_BITS;
    localparam int S_W      = ((PIX_FX_W > ERR_W) ? PIX_FX_W : ERR_W) + 2;
    localparam int DW       = S_W + 1;                  // 2*|s| + step
    localparam int DPW      = DW + (DW % 2);            // padded to whole digit pairs
    localparam int DIV_CYC  = DPW / 2;
    localparam int DCW      = $clog2(DIV_CYC + 1);
    localparam int DVW      = STEP_W + 1;               // divisor 2*step
    localparam int PW       = DPW + STEP_W;             // quotient * step
    localparam int E_W      = S_W + 1;                  // error s - q
    localparam int C_W      = E_W - 1;                  // one diffused share
    localparam int RW       = HEIGHT_W;                 // row counter

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [STEP_W-1:0]   quant_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            quant_step_reg   <= QUANT_STEP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_QUANT_STEP:   quant_step_reg   <= cfg_data[STEP_W-1:0];
                default: ;  // unmapped index: drop
            endcase
        end
    end

    // Effective geometry: zero means one, width clamps to the line buffer
    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [STEP_W-1:0]   step_eff;
    logic [DVW-1:0]      divisor;

    always_comb begin
        if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else if (image_width_reg == '0) begin
            w_eff = WW'(1);
        end else begin
            w_eff = WW'(image_width_reg);
        end
        h_eff    = (image_height_reg == '0) ? HEIGHT_W'(1) : image_height_reg;
        step_eff = (quant_step_reg == '0) ? STEP_W'(1) : quant_step_reg;
        divisor  = {step_eff, 1'b0};
    end

    // ------------------------------------------------------------------
    // Sequencer state and scan position
    // ------------------------------------------------------------------
    sedd_state_t state_reg, state_next;

    logic [CW-1:0]  cc_reg;          // pixels done in the current row
    logic [RW-1:0]  row_reg;         // current row
    logic signed [ERR_W-1:0] ahead_error_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic           m_tvalid_reg;

    // Per-item flags and payload (no reset needed)
    logic [PIX_W-1:0] pix_reg;
    logic [CW-1:0]    x_reg;
    logic             rev_reg;
    logic             col_zero_reg;
    logic             row_zero_reg;
    logic             has_ahead_reg;
    logic             below_reg;
    logic             last_reg;

    // Normalize the counters against the current geometry at accept time
    logic [CW-1:0] cc_n;
    logic [RW-1:0] row_inc, row_n;
    logic [WW-1:0] x_n;
    logic          rev_n;
    logic          cc_wrap;

    always_comb begin
        cc_wrap = (WW'(cc_reg) >= w_eff);
        cc_n    = cc_wrap ? '0 : cc_reg;
        row_inc = cc_wrap ? (row_reg + RW'(1)) : row_reg;
        row_n   = (row_inc >= h_eff) ? '0 : row_inc;
        rev_n   = row_n[0];
        x_n     = rev_n ? (w_eff - WW'(1) - WW'(cc_n)) : WW'(cc_n);
    end

    // Advance the counters at the end of an item
    logic [WW-1:0] cc_p;
    logic [RW-1:0] row_p;

    always_comb begin
        cc_p  = WW'(cc_reg) + WW'(1);
        row_p = row_reg + RW'(1);
    end

    // ------------------------------------------------------------------
    // Line memory: two row buffers, one write port, two registered reads
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] mem [DEPTH];
    logic signed [ERR_W-1:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0]           raddr_a, raddr_b, waddr;
    logic signed [ERR_W-1:0] wdata;
    logic                    we;

    function automatic logic [AW-1:0] buf_addr(input logic par, input logic [CW-1:0] col);
        logic [AW-1:0] base;
        base = par ? AW'(MAX_WIDTH) : '0;
        return base + AW'(col);
    endfunction

    logic [CW-1:0] behind_col, ahead_col;
    logic [AW-1:0] cur_addr, nxt_x_addr, nxt_bh_addr, nxt_ah_addr;

    always_comb begin
        behind_col  = rev_reg ? (x_reg + CW'(1)) : (x_reg - CW'(1));
        ahead_col   = rev_reg ? (x_reg - CW'(1)) : (x_reg + CW'(1));
        cur_addr    = buf_addr(rev_reg, x_reg);
        nxt_x_addr  = buf_addr(!rev_reg, x_reg);
        nxt_bh_addr = buf_addr(!rev_reg, behind_col);
        nxt_ah_addr = buf_addr(!rev_reg, ahead_col);
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic signed [S_W-1:0]   s_reg;
    logic signed [ERR_W-1:0] nxt_x_old_reg;
    logic signed [ERR_W-1:0] nxt_bh_old_reg;
    logic [DVW-1:0]          rem_reg;
    logic [DPW-1:0]          quo_reg;
    logic [PW-1:0]           prod_reg;
    logic signed [Q_W-1:0]   q_reg;
    logic signed [E_W-1:0]   e_reg;
    logic signed [C_W-1:0]   c7_reg, c5_reg, c3_reg, c1_reg;
    logic signed [Q_W-1:0]   q_out_reg;
    logic                    last_out_reg;

    // Error-corrected sample
    logic signed [S_W-1:0] pix_term, cur_term, ahead_term, s_next;

    always_comb begin
        pix_term   = $signed(S_W'(pix_reg) << FRAC_BITS);
        cur_term   = row_zero_reg ? '0 : S_W'(rd_a_reg);
        ahead_term = col_zero_reg ? '0 : S_W'(ahead_error_reg);
        s_next     = pix_term + cur_term + ahead_term;
    end

    // Rounding dividend: 2*|s| + step
    logic [S_W-1:0] s_mag;
    logic [DPW-1:0] dividend;

    always_comb begin
        s_mag    = s_reg[S_W-1] ? S_W'(-s_reg) : S_W'(s_reg);
        dividend = DPW'({s_mag, 1'b0}) + DPW'(step_eff);
    end

    // Single divider: two restoring steps per cycle
    logic [DVW-1:0] rem_step;
    logic [DPW-1:0] quo_step;

    always_comb begin
        logic [DVW:0] trial;
        logic         qbit;
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int i = 0; i < 2; i++) begin
            trial = {rem_step, quo_step[DPW-1]};
            qbit  = (trial >= {1'b0, divisor});
            if (qbit) begin
                trial = trial - {1'b0, divisor};
            end
            rem_step = trial[DVW-1:0];
            quo_step = {quo_step[DPW-2:0], qbit};
        end
    end

    // Saturate the rounded magnitude and restore the sign
    logic [Q_W-1:0]        q_mag;
    logic signed [Q_W-1:0] q_next;

    always_comb begin
        if (s_reg[S_W-1]) begin
            q_mag = (prod_reg > PW'(Q_NEG_MAG)) ? Q_W'(Q_NEG_MAG) : Q_W'(prod_reg);
        end else begin
            q_mag = (prod_reg > PW'(Q_POS_MAX)) ? Q_W'(Q_POS_MAX) : Q_W'(prod_reg);
        end
        q_next = s_reg[S_W-1] ? -$signed(q_mag) : $signed(q_mag);
    end

    // Weighted shares, floor of weight * e / 16
    logic signed [E_W+2:0] e_ext, t7, t5, t3;

    always_comb begin
        e_ext = (E_W+3)'(e_reg);
        t7    = (e_ext <<< 3) - e_ext;
        t5    = (e_ext <<< 2) + e_ext;
        t3    = (e_ext <<< 1) + e_ext;
    end

    // New line-buffer values
    logic signed [ERR_W-1:0] nxt_x_new, nxt_bh_new, nxt_ah_new;

    always_comb begin
        nxt_x_new  = col_zero_reg ? sat16(32'(c5_reg))
                                  : sat16(32'(nxt_x_old_reg) + 32'(c5_reg));
        nxt_bh_new = sat16(32'(nxt_bh_old_reg) + 32'(c3_reg));
        nxt_ah_new = sat16(32'(c1_reg));
    end

    // Memory port control
    always_comb begin
        raddr_a = cur_addr;
        raddr_b = (state_reg == ST_SUM) ? nxt_bh_addr : nxt_x_addr;
        we      = 1'b0;
        waddr   = nxt_x_addr;
        wdata   = nxt_x_new;
        case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = clr_addr_reg;
                wdata = '0;
            end
            ST_WR_X: begin
                we = below_reg;
            end
            ST_WR_BH: begin
                we    = below_reg && !col_zero_reg;
                waddr = nxt_bh_addr;
                wdata = nxt_bh_new;
            end
            ST_WR_AH: begin
                we    = below_reg && has_ahead_reg;
                waddr = nxt_ah_addr;
                wdata = nxt_ah_new;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_addr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_ABS;
            ST_ABS:   state_next = ST_DIV;
            ST_DIV:   if (div_cnt_reg == DCW'(DIV_CYC - 1)) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SAT;
            ST_SAT:   state_next = ST_ERR;
            ST_ERR:   state_next = ST_SHARE;
            ST_SHARE: state_next = ST_WR_X;
            ST_WR_X:  state_next = ST_WR_BH;
            ST_WR_BH: state_next = ST_WR_AH;
            ST_WR_AH: state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            div_cnt_reg     <= '0;
            cc_reg          <= '0;
            row_reg         <= '0;
            ahead_error_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end

            if (state_reg == ST_ABS) begin
                div_cnt_reg <= '0;
            end else if (state_reg == ST_DIV) begin
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end

            // Hold the normalized position for this item
            if (state_reg == ST_IDLE && s_tvalid) begin
                cc_reg  <= cc_n;
                row_reg <= row_n;
            end

            if (state_reg == ST_WR_X) begin
                ahead_error_reg <= has_ahead_reg ? sat16(32'(c7_reg)) : '0;
            end

            // Retire the item: load the new result and advance scan, else drop the taken one
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                if (cc_p >= w_eff) begin
                    cc_reg  <= '0;
                    row_reg <= (row_p >= h_eff) ? '0 : row_p;
                end else begin
                    cc_reg <= cc_p[CW-1:0];
                end
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload and datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pix_reg       <= s_tdata[PIX_W-1:0];
                    x_reg         <= x_n[CW-1:0];
                    rev_reg       <= rev_n;
                    col_zero_reg  <= (cc_n == '0);
                    row_zero_reg  <= (row_n == '0);
                    has_ahead_reg <= ((WW'(cc_n) + WW'(1)) < w_eff);
                    below_reg     <= ((row_n + RW'(1)) < h_eff);
                    last_reg      <= !((row_n + RW'(1)) < h_eff) &&
                                     !((WW'(cc_n) + WW'(1)) < w_eff);
                end
            end
            ST_SUM: begin
                s_reg         <= s_next;
                nxt_x_old_reg <= rd_b_reg;
            end
            ST_ABS: begin
                nxt_bh_old_reg <= rd_b_reg;
                rem_reg        <= '0;
                quo_reg        <= dividend;
            end
            ST_DIV: begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
            end
            ST_MUL: begin
                prod_reg <= PW'(quo_reg) * PW'(step_eff);
            end
            ST_SAT: begin
                q_reg <= q_next;
            end
            ST_ERR: begin
                e_reg <= E_W'(s_reg) - E_W'(q_reg);
            end
            ST_SHARE: begin
                c7_reg <= C_W'(t7 >>> 4);
                c5_reg <= C_W'(t5 >>> 4);
                c3_reg <= C_W'(t3 >>> 4);
                c1_reg <= C_W'(e_ext >>> 4);
            end
            ST_OUT: begin
                if (out_free) begin
                    q_out_reg    <= q_reg;
                    last_out_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(TDATA_OUT_W - Q_W)'(0), q_out_reg};
    assign m_tlast  = last_out_reg;

endmodule

`default_nettype wire

/* tb/dither_result_checker.sv */
// Checker for the serpentine dither block: mirrors its registers, predicts each level and compares.
`timescale 1ns / 1ps

module dither_result_checker
    import sedd_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int FRAC_BITS = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [TDATA_OUT_W-1:0] m_tdata,
    input  wire logic                   m_tlast,
    output int                          fail_count,
    output int                          pending,
    output int                          checked
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic signed [Q_W-1:0] level;
        logic                  frame_end;
    } dither_out_t;

    dither_out_t expected_levels[$];
    dither_out_t want;

    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [STEP_W-1:0]   cfg_step;

    shortint err_line[0:2*MAX_WIDTH-1];
    shortint carry_err;
    int      col_pos;
    int      row_pos;
    int      errors = 0;
    int      n_checked = 0;

    function automatic shortint clamp_err(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return shortint'(v);
    endfunction

    // Round half away from zero to a multiple of the step, then saturate.
    function automatic int round_to_step(input int s, input int step);
        int mag;
        int q;
        mag = (s < 0) ? -s : s;
        q = ((2 * mag + step) / (2 * step)) * step;
        if (s < 0) q = -q;
        if (q > Q_POS_MAX) q = Q_POS_MAX;
        if (q < -Q_NEG_MAG) q = -Q_NEG_MAG;
        return q;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0d, wanted %0d", $time, what, got, exp_val);
    endtask

    // Advance the dither state by one pixel and queue its expected level.
    task automatic dither_pixel(input logic [PIX_W-1:0] pix);
        int w, h, step, x, cur, nxt, s, q, e, c1, c3, c5, behind, front;
        bit rev, has_front;
        dither_out_t r;
        w = (cfg_width == 0) ? 1 : int'(cfg_width);
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (cfg_height == 0) ? 1 : int'(cfg_height);
        step = (cfg_step == 0) ? 1 : int'(cfg_step);

        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;

        rev = row_pos[0];
        x   = rev ? w - 1 - col_pos : col_pos;
        cur = rev ? MAX_WIDTH : 0;
        nxt = rev ? 0 : MAX_WIDTH;

        s = int'(pix) << FRAC_BITS;
        if (row_pos != 0) s += err_line[cur + x];
        if (col_pos != 0) s += carry_err;

        q = round_to_step(s, step);
        e = s - q;
        has_front = (col_pos + 1 < w);
        carry_err = has_front ? clamp_err((7 * e) >>> 4) : 16'sd0;

        if (row_pos + 1 < h) begin
            c3 = (3 * e) >>> 4;
            c5 = (5 * e) >>> 4;
            c1 = e >>> 4;
            if (col_pos == 0) begin
                err_line[nxt + x] = clamp_err(c5);
            end else begin
                behind = rev ? x + 1 : x - 1;
                err_line[nxt + behind] = clamp_err(err_line[nxt + behind] + c3);
                err_line[nxt + x] = clamp_err(err_line[nxt + x] + c5);
            end
            if (has_front) begin
                front = rev ? x - 1 : x + 1;
                err_line[nxt + front] = clamp_err(c1);
            end
        end

        r.level     = q[Q_W-1:0];
        r.frame_end = (row_pos + 1 >= h) && !has_front;
        expected_levels.push_back(r);

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width  = IMAGE_WIDTH_RST;
            cfg_height = IMAGE_HEIGHT_RST;
            cfg_step   = QUANT_STEP_RST;
            foreach (err_line[i]) err_line[i] = 16'sd0;
            carry_err = 16'sd0;
            col_pos   = 0;
            row_pos   = 0;
            expected_levels.delete();
            pending    <= 0;
            fail_count <= errors;
            checked    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  cfg_width  = cfg_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: cfg_height = cfg_data[HEIGHT_W-1:0];
                    REG_QUANT_STEP:   cfg_step   = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            // Compare before queuing, so a result never meets its own pixel.
            if (m_tvalid && m_tready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch("result with no pixel pending",
                                    int'($signed(m_tdata[Q_W-1:0])), 0);
                end else begin
                    want = expected_levels.pop_front();
                    n_checked++;
                    if (m_tdata[Q_W-1:0] !== want.level)
                        report_mismatch("quantized level", int'($signed(m_tdata[Q_W-1:0])),
                                        int'(want.level));
                    if (m_tdata[TDATA_OUT_W-1:Q_W] !== '0)
                        report_mismatch("tdata padding", int'(m_tdata[TDATA_OUT_W-1:Q_W]), 0);
                    if (m_tlast !== want.frame_end)
                        report_mismatch("frame end flag", int'(m_tlast), int'(want.frame_end));
                end
            end
            if (s_tvalid && s_tready) dither_pixel(s_tdata[PIX_W-1:0]);
            pending    <= expected_levels.size();
            fail_count <= errors;
            checked    <= n_checked;
        end
    end

endmodule

/* tb/tb_serpentine_error_diffusion_dither_top.sv */
// Testbench top: drives pixels and register writes into the dither block and gives the verdict.
`timescale 1ns / 1ps

module tb_serpentine_error_diffusion_dither_top;
    import sedd_pkg::*;

    localparam int MAX_WIDTH     = 2048;
    localparam int FRAC_BITS     = 4;
    localparam int RANDOM_PIXELS = 1500;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int HOLD_SPACING  = 1800;
    localparam int QUIET_LIMIT   = 20000;  // covers the line-buffer clear after reset
    localparam int TAIL_CYCLES   = 50;

    // Writes to this index land on no register.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic aclk;
    logic aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;    // [7:0] pixel_value

    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;          // [13:0] quantized_value, [15:14] zero
    logic                   m_tlast;          // frame_last

    int fail_count;
    int pending;
    int checked;

    // Activity counters, kept by the watchdog process.
    int quiet_cycles  = 0;
    int results_taken = 0;
    int frames_seen   = 0;

    // Sender bookkeeping.
    int pixels_sent   = 0;
    int burst_left    = 0;
    int settings_used = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    serpentine_error_diffusion_dither_top #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    dither_result_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Hold one register write on the channel until it is taken. The caller
    // drops cfg_valid after its last write, so valid never toggles within a step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Write the registers picked by mask (bit 0 width, bit 1 height, bit 2 step).
    task automatic program_regs(input bit [2:0] mask, input logic [CFG_DATA_W-1:0] wdata,
                                input logic [CFG_DATA_W-1:0] hdata,
                                input logic [CFG_DATA_W-1:0] sdata);
        if (mask[0]) write_reg(REG_IMAGE_WIDTH, wdata);
        if (mask[1]) write_reg(REG_IMAGE_HEIGHT, hdata);
        if (mask[2]) write_reg(REG_QUANT_STEP, sdata);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Offer one pixel. The sender runs in bursts; a new burst may open with a gap.
    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    // Stop offering and wait until every result is back and the block is idle.
    // The first edge lets the checker count a pixel taken on this very edge.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || !s_tready) @(posedge aclk);
    endtask

    // Bias toward the extremes and toward values near a half step of 16.
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(120, 136));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : stimulus
        logic [PIX_W-1:0] pix_list[$];
        logic [CFG_DATA_W-1:0] wdata, hdata, sdata;
        int directed_sent;
        int sel, wv, hv, sv, ew, eh, n;
        bit [2:0] mask;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Small 3x3 frame: row starts, a reverse row, last row, last pixel and frame wrap.
        program_regs(3'b111, 13'd3, 13'd3, 13'd16);
        pix_list = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd255, 8'd0, 8'd1, 8'd254, 8'd8};
        foreach (pix_list[i]) push_pixel(pix_list[i]);

        // Zero width, height and step read as one: every pixel ends a frame.
        wait_idle();
        program_regs(3'b111, 13'd0, 13'd0, 13'd0);
        pix_list = '{8'd255, 8'd0};
        foreach (pix_list[i]) push_pixel(pix_list[i]);

        // All data bits set: width clips to the maximum row, step is the largest code.
        wait_idle();
        program_regs(3'b111, 13'h1FFF, 13'd4, 13'h1FFF);
        pix_list = '{8'd255, 8'd0, 8'd128};
        foreach (pix_list[i]) push_pixel(pix_list[i]);

        // Tallest plane, narrow rows, the coarsest nominal step.
        wait_idle();
        program_regs(3'b111, 13'd2, 13'h1FFF, 13'd4080);
        pix_list = '{8'd255, 8'd255, 8'd0, 8'd200};
        foreach (pix_list[i]) push_pixel(pix_list[i]);

        // Shrink the width while the column counter sits beyond it: a new row starts.
        wait_idle();
        program_regs(3'b111, 13'd6, 13'd5, 13'd20);
        pix_list = '{8'd37, 8'd99, 8'd160, 8'd240};
        foreach (pix_list[i]) push_pixel(pix_list[i]);
        wait_idle();
        write_reg(REG_SPARE, 13'h1FFF);
        program_regs(3'b001, 13'd2, 13'd0, 13'd0);
        pix_list = '{8'd17, 8'd250, 8'd64};
        foreach (pix_list[i]) push_pixel(pix_list[i]);

        directed_sent = pixels_sent;

        // Random phases: new geometry and step each time, counters carried over.
        while (pixels_sent < directed_sent + RANDOM_PIXELS) begin
            wait_idle();
            sel = $urandom_range(0, 19);
            if (sel == 0) wv = 0;
            else if (sel == 1) wv = $urandom_range(2049, 4095);
            else wv = $urandom_range(1, 24);
            sel = $urandom_range(0, 19);
            if (sel == 0) hv = 0;
            else if (sel == 1) hv = $urandom_range(7, 8191);
            else hv = $urandom_range(1, 6);
            case ($urandom_range(0, 9))
                0:       sv = 0;
                1:       sv = 4095;
                2:       sv = 4080;
                3, 4:    sv = $urandom_range(65, 4095);
                default: sv = $urandom_range(1, 64);
            endcase
            // Bit 12 of the width and step writes is ignored by the block.
            wdata = (13'($urandom_range(0, 1)) << 12) | 13'(wv);
            hdata = 13'(hv);
            sdata = (13'($urandom_range(0, 1)) << 12) | 13'(sv);
            mask  = (settings_used == 6) ? 3'b111 : 3'($urandom_range(1, 7));
            program_regs(mask, wdata, hdata, sdata);

            ew = (wv == 0) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv);
            eh = (hv == 0) ? 1 : hv;
            if (ew * eh <= 96 && $urandom_range(0, 1) == 1)
                n = ew * eh + $urandom_range(0, 4);
            else
                n = $urandom_range(4, 60);
            repeat (n) push_pixel(pick_pixel());
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d pixels over %0d register settings, zero, oversize and shrunk",
                 pixels_sent, settings_used);
        $display("%0d levels compared, %0d frame ends seen", checked, frames_seen);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Receiver: stalls on a random pattern of its own, with runs of steady
    // readiness, and now and then holds off long enough to back the block up.
    initial begin : receiver
        int mode;
        int len;
        int next_hold_at;
        next_hold_at = 150;
        forever begin
            if (results_taken >= next_hold_at && s_tvalid) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                next_hold_at = next_hold_at + HOLD_SPACING;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(4, 60);
                repeat (len) begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 3) != 0);
                        2:       m_tready <= ($urandom_range(0, 1) == 1);
                        default: m_tready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (m_tvalid && m_tready) begin
            results_taken <= results_taken + 1;
            if (m_tlast) frames_seen <= frames_seen + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
